FILE: hw/rtl/at_response_and_ipd_deframer_core_assert.svh
// Assertion macros for the AT response and IPD deframer.
// Used by the top level only; expects signals clk and arst_n in scope.
`ifndef AT_RESPONSE_AND_IPD_DEFRAMER_CORE_ASSERT_SVH
`define AT_RESPONSE_AND_IPD_DEFRAMER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ATRD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed in the same cycle");
`define ATRD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed one cycle later");
`else
`define ATRD_ASSERT_IMP(lbl, ante, cons)
`define ATRD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/atrd_pkg.sv
// Shared types and constants for the AT response and IPD deframer.
// No dependencies; imported by every module of the block.
package atrd_pkg;

	localparam int MAX_FRAME_DEF = 256;

	// Width of the net frame length compare: 5 + 16-bit length + 8-bit header count.
	localparam int LEN_CMP_W = 17;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_R     = 8'h52;

	// Header digits start at this frame position; a net frame spans this many fixed bytes.
	localparam int NET_HDR_POS  = 4;
	localparam int NET_HDR_BASE = 5;

	typedef enum logic [1:0] {
		MODE_NET     = 2'd0,
		MODE_RSP     = 2'd1,
		MODE_DISCARD = 2'd2,
		MODE_SMART   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        frame_end;
		logic [8:0]  frame_length;
		logic [15:0] payload_length;
		logic        overflow;
	} res_t;

endpackage

FILE: hw/rtl/atrd_frame_fsm.sv
// Framing state and per-byte update of the deframer.
// Depends on atrd_pkg; each byte is processed combinationally and registered on step.
module atrd_frame_fsm
	import atrd_pkg::*;
#(
	parameter int MaxFrame = MAX_FRAME_DEF,
	localparam int CntW = $clog2(MaxFrame + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            mode_we,
	input  logic [1:0]      mode_wdata,
	input  logic            step,
	input  logic [7:0]      byte_in,
	output logic            emit,
	output res_t            res,
	output logic [CntW-1:0] frame_cnt,
	output logic            frame_open
);

	mode_t            mode_q;
	logic [CntW-1:0]  cnt_q, cnt_n;
	logic             open_q, open_n;
	logic             hdr_done_q, hdr_done_n;
	logic [15:0]      acc_q, acc_n;
	logic [7:0]       hdr_chars_q, hdr_chars_n;
	logic [7:0]       prev_q, prev2_q;
	logic             norm_end;
	logic             ovf;
	logic             fin;

	always_comb begin
		cnt_n       = cnt_q;
		open_n      = open_q;
		hdr_done_n  = hdr_done_q;
		acc_n       = acc_q;
		hdr_chars_n = hdr_chars_q;
		emit        = 1'b0;
		norm_end    = 1'b0;
		unique case (mode_q)
			MODE_DISCARD: begin
				emit = 1'b0;
			end
			MODE_NET: begin
				if (!open_q) begin
					if (byte_in == CH_PLUS) begin
						open_n = 1'b1;
					end
				end else begin
					if (!hdr_done_q) begin
						if (byte_in == CH_COLON) begin
							hdr_done_n = 1'b1;
						end else if (cnt_q >= CntW'(NET_HDR_POS)) begin
							if (byte_in == CH_COMMA) begin
								acc_n = '0;
							end else begin
								// Non-digits are folded in the same way as digits.
								acc_n = (acc_q << 3) + (acc_q << 1) + {8'b0, byte_in}
									- {8'b0, CH_ZERO};
							end
							hdr_chars_n = hdr_chars_q + 8'd1;
						end
					end
					cnt_n    = cnt_q + CntW'(1);
					emit     = 1'b1;
					norm_end = hdr_done_n && (LEN_CMP_W'(cnt_n) == LEN_CMP_W'(NET_HDR_BASE)
						+ LEN_CMP_W'(acc_n) + LEN_CMP_W'(hdr_chars_n));
				end
			end
			MODE_RSP: begin
				if (!(byte_in == CH_SPACE || byte_in == CH_NUL || byte_in == CH_CR
						|| byte_in == CH_LF || byte_in == CH_PLUS)) begin
					cnt_n    = cnt_q + CntW'(1);
					emit     = 1'b1;
					norm_end = (byte_in == CH_K && prev_q == CH_O)
						|| (byte_in == CH_R && prev_q == CH_O && prev2_q == CH_R);
				end
			end
			MODE_SMART: begin
				cnt_n    = cnt_q + CntW'(1);
				emit     = 1'b1;
				norm_end = (byte_in == CH_K && prev_q == CH_O);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		ovf = !norm_end && (cnt_n >= CntW'(MaxFrame));
		fin = norm_end || ovf;
	end

	assign res.out_byte       = byte_in;
	assign res.frame_end      = fin;
	assign res.frame_length   = 9'(cnt_n);
	assign res.payload_length = (mode_q == MODE_NET) ? acc_n : 16'd0;
	assign res.overflow       = ovf;

	assign frame_cnt  = cnt_q;
	assign frame_open = open_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NET;
			cnt_q       <= '0;
			open_q      <= 1'b0;
			hdr_done_q  <= 1'b0;
			acc_q       <= '0;
			hdr_chars_q <= '0;
			prev_q      <= '0;
			prev2_q     <= '0;
		end else if (mode_we) begin
			// A mode change abandons whatever frame is in progress.
			mode_q      <= mode_t'(mode_wdata);
			cnt_q       <= '0;
			open_q      <= 1'b0;
			hdr_done_q  <= 1'b0;
			acc_q       <= '0;
			hdr_chars_q <= '0;
			prev_q      <= '0;
			prev2_q     <= '0;
		end else if (step) begin
			if (emit && fin) begin
				cnt_q       <= '0;
				open_q      <= 1'b0;
				hdr_done_q  <= 1'b0;
				acc_q       <= '0;
				hdr_chars_q <= '0;
				prev_q      <= '0;
				prev2_q     <= '0;
			end else begin
				cnt_q       <= cnt_n;
				open_q      <= open_n;
				hdr_done_q  <= hdr_done_n;
				acc_q       <= acc_n;
				hdr_chars_q <= hdr_chars_n;
				if (emit) begin
					prev_q  <= byte_in;
					prev2_q <= prev_q;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/atrd_out_reg.sv
// Result register of the deframer with valid/stall handshake.
// Depends on atrd_pkg for the result word type.
module atrd_out_reg
	import atrd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	input  logic stall,
	output logic valid,
	output logic free,
	output res_t res_out
);

	logic valid_q;
	res_t res_q;

	// The register can take a new word when empty or when its word leaves this cycle.
	assign free    = !valid_q || !stall;
	assign valid   = valid_q;
	assign res_out = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

FILE: hw/rtl/at_response_and_ipd_deframer_core.sv
// Top level of the AT response and IPD deframer.
// Depends on atrd_pkg, atrd_frame_fsm, atrd_out_reg and the assertion header.

// Frames bytes received from an AT-command modem according to rx_mode (0 net
// "+IPD" frames, 1 command responses closed by OK or ERROR, 2 discard, 3 smart
// link closed by OK). One byte is accepted every cycle while rx_stall is low;
// a kept byte passes through the input register and then the result register,
// with the whole framing update done combinationally between them. A byte
// that is dropped gives no result. Writing rx_mode abandons any partial frame
// and should only be done while no byte is in flight. A frame that reaches
// MaxFrame bytes is closed with overflow set.
`include "at_response_and_ipd_deframer_core_assert.svh"

module at_response_and_ipd_deframer_core
	import atrd_pkg::*;
#(
	parameter int MaxFrame = MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_mode_we,
	input  logic [1:0]  rx_mode,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  out_byte,
	output logic        frame_end,
	output logic [8:0]  frame_length,
	output logic [15:0] payload_length,
	output logic        overflow
);

	localparam int CntW = $clog2(MaxFrame + 1);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            emit;
	logic            slot_free;
	logic            advance;
	res_t            res_next;
	res_t            res_cur;
	logic [CntW-1:0] frame_cnt;
	logic            frame_open;

	// A word without a result moves on even when the result register is full.
	assign advance  = valid_s1 && (!emit || slot_free);
	assign rx_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_valid && !rx_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	atrd_frame_fsm #(
		.MaxFrame(MaxFrame)
	) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode_we   (rx_mode_we),
		.mode_wdata(rx_mode),
		.step      (advance),
		.byte_in   (byte_s1),
		.emit      (emit),
		.res       (res_next),
		.frame_cnt (frame_cnt),
		.frame_open(frame_open)
	);

	atrd_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && emit),
		.res_in (res_next),
		.stall  (res_stall),
		.valid  (res_valid),
		.free   (slot_free),
		.res_out(res_cur)
	);

	assign out_byte       = res_cur.out_byte;
	assign frame_end      = res_cur.frame_end;
	assign frame_length   = res_cur.frame_length;
	assign payload_length = res_cur.payload_length;
	assign overflow       = res_cur.overflow;

	`ATRD_ASSERT_IMP(a_cnt_bound, 1'b1, frame_cnt <= CntW'(MaxFrame))
	`ATRD_ASSERT_IMP(a_ovf_closes, res_valid && overflow, frame_end && frame_length == 9'(MaxFrame))
	`ATRD_ASSERT_NXT(a_mode_clears, rx_mode_we, frame_cnt == '0 && !frame_open)

endmodule
